@@ hdl/nfa_complement_acceptor_macros.svh @@
// Assertion helpers shared by the acceptor RTL.
`ifndef NFA_COMPLEMENT_ACCEPTOR_MACROS_SVH
`define NFA_COMPLEMENT_ACCEPTOR_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define NCA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the following cycle.
`define NCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/nca_pkg.sv @@
`timescale 1ns / 1ps

package nca_pkg;

   // Automaton size
   localparam int NUM_STATES  = 16;
   localparam int NUM_SYMBOLS = 8;

   // Field widths
   localparam int CMD_W   = 2;
   localparam int STATE_W = 4;
   localparam int SLOT_W  = 3;
   localparam int MASK_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 4;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Internal address widths
   localparam int SLOT_ADDR_W  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
   localparam int STATE_ADDR_W = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

   // Mask bits that name real states
   localparam logic [MASK_W-1:0] STATE_BITS = MASK_W'({NUM_STATES{1'b1}});

   // Commands
   localparam logic [CMD_W-1:0] CMD_LOAD_ALPHA = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_ROW   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_BEGIN      = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SYMBOL     = 2'd3;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_MASK   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FINAL_MASK     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHABET_COUNT = 2'd2;

   // Item held in the compute stage
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             hit;
   } stage_item_type;

endpackage

@@ hdl/nca_ram.sv @@
`timescale 1ns / 1ps

module nca_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                            clock,
   input  logic                                            wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    wr_addr,
   input  logic [WIDTH-1:0]                                wr_data,
   input  logic                                            rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    rd_addr,
   output logic [WIDTH-1:0]                                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/nfa_complement_acceptor.sv @@
`timescale 1ns / 1ps

// Runs a loaded NFA by subset tracking and reports membership in the complement of its
// language. Load items (alphabet slot, transition row) update the tables at acceptance
// and give no result; begin and feed-symbol items each give one result, which passes
// through the compute stage register and then the result register. One item is taken
// every clock unless a result waiting on rsp_ready backs up the pipe: the alphabet lookup
// and row memory read happen at acceptance, and the next subset (an AND-OR over the 16
// per-state row memories) is formed in the compute stage ahead of the result register.
// Transition rows read as zero until loaded (per-entry valid bits), so no clearing pass
// is needed after reset.
module nfa_complement_acceptor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [nca_pkg::CMD_W-1:0]         req_command,
   input  logic [nca_pkg::STATE_W-1:0]       req_nfa_state,
   input  logic [nca_pkg::SLOT_W-1:0]        req_symbol_slot,
   input  logic [nca_pkg::MASK_W-1:0]        req_next_mask,
   input  logic [nca_pkg::BYTE_W-1:0]        req_symbol_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_accepted,
   output logic [nca_pkg::MASK_W-1:0]        rsp_active_set,
   input  logic                              csr_write_enable,
   input  logic [nca_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [nca_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   import nca_pkg::*;

`include "nfa_complement_acceptor_macros.svh"

   // Configuration
   logic [MASK_W-1:0]      initial_mask_ff;
   logic [MASK_W-1:0]      final_mask_ff;
   logic [COUNT_W-1:0]     alphabet_count_ff;

   // Tables
   logic [BYTE_W-1:0]      alphabet_ff [NUM_SYMBOLS];
   logic [NUM_SYMBOLS-1:0] row_valid_ff [NUM_STATES];
   logic [MASK_W-1:0]      row_data [NUM_STATES];

   // Compute stage
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   stage_item_type         s1_item_ff;
   logic [NUM_STATES-1:0]  s1_row_valid_ff;

   // Automaton state
   logic [MASK_W-1:0]      active_ff;
   logic [MASK_W-1:0]      active_in;
   logic                   dead_ff;
   logic                   dead_in;

   // Result register
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_accepted_ff;
   logic [MASK_W-1:0]      rsp_active_set_ff;

   logic                   req_accept;
   logic                   s1_advance;
   logic                   slot_in_range;
   logic                   state_in_range;
   logic                   alpha_we;
   logic                   row_we;
   logic                   row_rd;
   logic                   hit;
   logic [SLOT_ADDR_W-1:0] hit_slot;
   logic [SLOT_ADDR_W-1:0] wr_slot;
   logic [STATE_ADDR_W-1:0] wr_state;
   logic [MASK_W-1:0]      union_mask;
   logic                   accepted_in;

   // Handshake
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_accept = req_valid && req_ready;

   // Load decode
   assign slot_in_range  = 32'(req_symbol_slot) < NUM_SYMBOLS;
   assign state_in_range = 32'(req_nfa_state) < NUM_STATES;
   assign wr_slot        = req_symbol_slot[SLOT_ADDR_W-1:0];
   assign wr_state       = req_nfa_state[STATE_ADDR_W-1:0];
   assign alpha_we = req_accept && (req_command == CMD_LOAD_ALPHA) && slot_in_range;
   assign row_we   = req_accept && (req_command == CMD_LOAD_ROW) && slot_in_range
                     && state_in_range;
   assign row_rd   = req_accept && (req_command == CMD_SYMBOL);

   // Alphabet lookup: lowest valid slot holding the byte wins
   always_comb begin
      hit      = 1'b0;
      hit_slot = '0;
      for (int i = NUM_SYMBOLS - 1; i >= 0; i--) begin
         if ((i < int'(alphabet_count_ff)) && (alphabet_ff[i] == req_symbol_byte)) begin
            hit      = 1'b1;
            hit_slot = SLOT_ADDR_W'(i);
         end
      end
   end

   // One row memory per source state, addressed by alphabet slot
   for (genvar q = 0; q < NUM_STATES; q++) begin : g_row
      nca_ram #(
         .WIDTH (MASK_W),
         .DEPTH (NUM_SYMBOLS)
      ) u_row_ram (
         .clock   (clock),
         .wr_en   (row_we && (wr_state == STATE_ADDR_W'(q))),
         .wr_addr (wr_slot),
         .wr_data (req_next_mask & STATE_BITS),
         .rd_en   (row_rd),
         .rd_addr (hit_slot),
         .rd_data (row_data[q])
      );
   end

   // OR of the rows of all active states
   always_comb begin
      union_mask = '0;
      for (int q = 0; q < NUM_STATES; q++) begin
         if (active_ff[q] && s1_row_valid_ff[q]) begin
            union_mask = union_mask | row_data[q];
         end
      end
   end

   // Next subset and dead flag
   always_comb begin
      active_in = active_ff;
      dead_in   = dead_ff;
      priority if (s1_item_ff.cmd == CMD_BEGIN) begin
         active_in = initial_mask_ff & STATE_BITS;
         dead_in   = 1'b0;
      end else if (dead_ff) begin
         active_in = active_ff;
      end else if (!s1_item_ff.hit) begin
         dead_in = 1'b1;
      end else begin
         active_in = union_mask & STATE_BITS;
      end
      accepted_in = !dead_in && ((active_in & final_mask_ff) == '0);
   end

   always_comb begin
      s1_valid_in = s1_valid_ff && !s1_advance;
      if (req_accept && ((req_command == CMD_BEGIN) || (req_command == CMD_SYMBOL))) begin
         s1_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control and reset-valued state
   always_ff @(posedge clock) begin
      if (reset) begin
         initial_mask_ff   <= MASK_W'(1);
         final_mask_ff     <= '0;
         alphabet_count_ff <= '0;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         active_ff         <= '0;
         dead_ff           <= 1'b0;
         for (int i = 0; i < NUM_SYMBOLS; i++) begin
            alphabet_ff[i] <= '0;
         end
         for (int q = 0; q < NUM_STATES; q++) begin
            row_valid_ff[q] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_INITIAL_MASK:   initial_mask_ff   <= csr_write_data[MASK_W-1:0];
               CSR_FINAL_MASK:     final_mask_ff     <= csr_write_data[MASK_W-1:0];
               CSR_ALPHABET_COUNT: alphabet_count_ff <= csr_write_data[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (alpha_we) begin
            alphabet_ff[wr_slot] <= req_symbol_byte;
         end
         if (row_we) begin
            row_valid_ff[wr_state][wr_slot] <= 1'b1;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_advance) begin
            active_ff <= active_in;
            dead_ff   <= dead_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff.cmd <= req_command;
         s1_item_ff.hit <= hit;
      end
      if (row_rd) begin
         for (int q = 0; q < NUM_STATES; q++) begin
            s1_row_valid_ff[q] <= row_valid_ff[q][hit_slot];
         end
      end
      if (s1_advance) begin
         rsp_accepted_ff   <= accepted_in;
         rsp_active_set_ff <= active_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_accepted_ff;
   assign rsp_active_set = rsp_active_set_ff;

   // Checks
   `NCA_ASSERT_SAME(a_stage_cmd, clock, reset, s1_valid_ff, (s1_item_ff.cmd == CMD_BEGIN) || (s1_item_ff.cmd == CMD_SYMBOL), "load item in compute stage")
   `NCA_ASSERT_NEXT(a_begin_clears, clock, reset, s1_advance && (s1_item_ff.cmd == CMD_BEGIN), !dead_ff, "begin left dead flag set")
   `NCA_ASSERT_NEXT(a_dead_rejects, clock, reset, s1_advance && dead_in, rsp_valid_ff && !rsp_accepted_ff, "dead word reported accepted")
   `NCA_ASSERT_SAME(a_stall_full, clock, reset, !req_ready, s1_valid_ff && rsp_valid_ff, "stall without full pipeline")

endmodule

@@ tb/complement_run_checker.sv @@
`timescale 1ns / 1ps

module complement_run_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [nca_pkg::CMD_W-1:0]       req_command,
   input  logic [nca_pkg::STATE_W-1:0]     req_nfa_state,
   input  logic [nca_pkg::SLOT_W-1:0]      req_symbol_slot,
   input  logic [nca_pkg::MASK_W-1:0]      req_next_mask,
   input  logic [nca_pkg::BYTE_W-1:0]      req_symbol_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_accepted,
   input  logic [nca_pkg::MASK_W-1:0]      rsp_active_set,
   input  logic                            csr_write_enable,
   input  logic [nca_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nca_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int unsigned                     fail_count,
   output int unsigned                     pending
);

   import nca_pkg::*;

   localparam int PRINT_CAP = 60;

   typedef struct packed {
      logic              accepted;
      logic [MASK_W-1:0] active_set;
   } verdict_type;

   // Shadow automaton: tables, run state and register copies
   logic [MASK_W-1:0]  row_masks [NUM_STATES][NUM_SYMBOLS];
   logic [BYTE_W-1:0]  alpha_bytes [NUM_SYMBOLS];
   logic [MASK_W-1:0]  subset;
   logic               dead;
   logic [MASK_W-1:0]  start_states;
   logic [MASK_W-1:0]  final_states;
   logic [COUNT_W-1:0] alpha_count;

   verdict_type verdicts_due [$];

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= PRINT_CAP) begin
         $display("%0t: mismatch: %s", $time, what);
      end
   endtask

   // Advance the subset tracker by one accepted item
   task automatic step_automaton(input logic [CMD_W-1:0] cmd, input logic [STATE_W-1:0] st,
                                 input logic [SLOT_W-1:0] slot,
                                 input logic [MASK_W-1:0] nmask,
                                 input logic [BYTE_W-1:0] sym);
      int                hit;
      int                live;
      logic [MASK_W-1:0] next_set;
      verdict_type       v;
      hit  = -1;
      live = (alpha_count > NUM_SYMBOLS) ? NUM_SYMBOLS : int'(alpha_count);
      if (cmd == CMD_LOAD_ALPHA) begin
         alpha_bytes[slot] = sym;
      end else if (cmd == CMD_LOAD_ROW) begin
         row_masks[st][slot] = nmask & STATE_BITS;
      end else begin
         if (cmd == CMD_BEGIN) begin
            subset = start_states & STATE_BITS;
            dead   = 1'b0;
         end else if (!dead) begin
            // lowest live slot holding the byte wins
            for (int i = 0; i < live; i++) begin
               if (hit < 0 && alpha_bytes[i] == sym) hit = i;
            end
            if (hit < 0) begin
               dead = 1'b1;
            end else begin
               next_set = '0;
               for (int q = 0; q < NUM_STATES; q++) begin
                  if (subset[q]) next_set |= row_masks[q][hit];
               end
               subset = next_set & STATE_BITS;
            end
         end
         v.accepted   = !dead && ((subset & final_states) == '0);
         v.active_set = subset;
         verdicts_due.push_back(v);
      end
   endtask

   // Watch the register port and both channels
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         foreach (row_masks[q, s]) row_masks[q][s] = '0;
         foreach (alpha_bytes[s]) alpha_bytes[s] = '0;
         subset       = '0;
         dead         = 1'b0;
         start_states = MASK_W'(1);
         final_states = '0;
         alpha_count  = '0;
         verdicts_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_INITIAL_MASK:   start_states = csr_write_data[MASK_W-1:0];
               CSR_FINAL_MASK:     final_states = csr_write_data[MASK_W-1:0];
               CSR_ALPHABET_COUNT: alpha_count  = csr_write_data[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            step_automaton(req_command, req_nfa_state, req_symbol_slot, req_next_mask,
                           req_symbol_byte);
         end
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               report_mismatch($sformatf("result with nothing due (active_set %04h)",
                                         rsp_active_set));
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_accepted !== want.accepted) begin
                  report_mismatch($sformatf("accepted got %b want %b",
                                            rsp_accepted, want.accepted));
               end
               if (rsp_active_set !== want.active_set) begin
                  report_mismatch($sformatf("active_set got %04h want %04h",
                                            rsp_active_set, want.active_set));
               end
            end
         end
      end
      pending <= verdicts_due.size();
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import nca_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 12;
   localparam int LIMIT_NS      = 2_000_000;
   localparam int RANDOM_ITEMS  = 700;
   localparam int RANDOM_PHASES = 8;
   localparam int HOLD_OFF      = 400;

   // Index with no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [CMD_W-1:0]       req_command;
   logic [STATE_W-1:0]     req_nfa_state;
   logic [SLOT_W-1:0]      req_symbol_slot;
   logic [MASK_W-1:0]      req_next_mask;
   logic [BYTE_W-1:0]      req_symbol_byte;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_accepted;
   logic [MASK_W-1:0]      rsp_active_set;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   int unsigned            fail_count;
   int unsigned            pending;

   // Stimulus bookkeeping
   logic [BYTE_W-1:0] loaded_bytes [NUM_SYMBOLS];
   int                live_slots = 0;
   int                burst_left = 0;
   int                items_sent = 0;
   int                hold_offs_asked = 0;

   nfa_complement_acceptor i_dut (.*);

   complement_run_checker i_check (.*);

   always #(HALF_PERIOD) clock = ~clock;

   initial begin : watchdog
      #(LIMIT_NS);
      $display("Regression FAIL");
      $finish;
   end

   // Receiver: ready pattern in segments, plus long hold-offs on request
   initial begin : rsp_side
      int span;
      int mode;
      int hold_offs_done;
      hold_offs_done = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_offs_done < hold_offs_asked) begin
            hold_offs_done++;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
         end
         mode = $urandom_range(0, 2);
         span = $urandom_range(1, 40);
         repeat (span) begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   function automatic logic [MASK_W-1:0] pick_mask();
      logic [MASK_W-1:0] m;
      case ($urandom_range(0, 5))
         0:       m = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
         1:       m = (MASK_W'(1) << $urandom_range(0, MASK_W - 1)) |
                      (MASK_W'(1) << $urandom_range(0, MASK_W - 1));
         2:       m = MASK_W'($urandom & $urandom & $urandom);
         3:       m = MASK_W'($urandom);
         4:       m = '1;
         default: m = '0;
      endcase
      return m;
   endfunction

   // Offer one item; bursts of random length separated by random gaps
   task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [STATE_W-1:0] st,
                             input logic [SLOT_W-1:0] slot, input logic [MASK_W-1:0] nmask,
                             input logic [BYTE_W-1:0] sym);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_nfa_state   <= st;
      req_symbol_slot <= slot;
      req_next_mask   <= nmask;
      req_symbol_byte <= sym;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      items_sent++;
      if (cmd == CMD_LOAD_ALPHA) loaded_bytes[slot] = sym;
   endtask

   task automatic offer_symbol();
      logic [BYTE_W-1:0] sym;
      sym = BYTE_W'($urandom);
      if (live_slots > 0 && $urandom_range(0, 9) != 0) begin
         sym = loaded_bytes[$urandom_range(0, live_slots - 1)];
      end
      offer_item(CMD_SYMBOL, STATE_W'($urandom), SLOT_W'($urandom), MASK_W'($urandom), sym);
   endtask

   // A begin item followed by a short run of symbols
   task automatic run_word();
      int len;
      len = $urandom_range(0, 12);
      offer_item(CMD_BEGIN, STATE_W'($urandom), SLOT_W'($urandom), MASK_W'($urandom),
                 BYTE_W'($urandom));
      repeat (len) offer_symbol();
   endtask

   // Wait until every due result is back and the pipe has emptied
   task automatic settle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input logic [MASK_W-1:0] start_set,
                             input logic [MASK_W-1:0] accept_set,
                             input logic [COUNT_W-1:0] count);
      logic [CSR_DATA_W-1:0] spare;
      spare = CSR_DATA_W'($urandom);
      csr_write_enable <= 1'b1;
      if ($urandom_range(0, 2) == 0) begin
         csr_index      <= CSR_SPARE;
         csr_write_data <= spare;
         @(posedge clock);
      end
      csr_index      <= CSR_INITIAL_MASK;
      csr_write_data <= start_set;
      @(posedge clock);
      csr_index      <= CSR_FINAL_MASK;
      csr_write_data <= accept_set;
      @(posedge clock);
      // upper data bits carry junk that the count must ignore
      csr_index      <= CSR_ALPHABET_COUNT;
      csr_write_data <= {spare[CSR_DATA_W-1:COUNT_W], count};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      live_slots = (count > NUM_SYMBOLS) ? NUM_SYMBOLS : int'(count);
   endtask

   initial begin : stimulus
      int                 phase_end;
      int                 pick;
      logic [COUNT_W-1:0] count_pick;
      logic [BYTE_W-1:0]  sym;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_command      <= CMD_LOAD_ALPHA;
      req_nfa_state    <= '0;
      req_symbol_slot  <= '0;
      req_next_mask    <= '0;
      req_symbol_byte  <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_INITIAL_MASK;
      csr_write_data   <= '0;
      foreach (loaded_bytes[s]) loaded_bytes[s] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: tables loaded under reset register values, duplicate byte in slot 4
      offer_item(CMD_LOAD_ALPHA, '0, 3'd0, '0, 8'h00);
      offer_item(CMD_LOAD_ALPHA, '1, 3'd1, '1, 8'hFF);
      offer_item(CMD_LOAD_ALPHA, '0, 3'd2, '0, 8'h41);
      offer_item(CMD_LOAD_ALPHA, '0, 3'd3, '0, 8'h42);
      offer_item(CMD_LOAD_ALPHA, '0, 3'd4, '0, 8'h41);
      offer_item(CMD_LOAD_ALPHA, '0, 3'd5, '0, 8'h7F);
      offer_item(CMD_LOAD_ALPHA, '0, 3'd6, '0, 8'h80);
      offer_item(CMD_LOAD_ALPHA, '0, 3'd7, '0, 8'h55);
      offer_item(CMD_LOAD_ROW, 4'd0, 3'd0, 16'h0006, 8'h00);
      offer_item(CMD_LOAD_ROW, 4'd1, 3'd2, 16'hFFFF, 8'hFF);
      offer_item(CMD_LOAD_ROW, 4'd15, 3'd7, 16'h8001, 8'h00);
      offer_item(CMD_LOAD_ROW, 4'd2, 3'd4, 16'h1234, 8'h00);
      offer_item(CMD_LOAD_ROW, 4'd3, 3'd1, 16'h0000, 8'h00);
      settle();
      // count above the table size, single start state, top state final
      write_regs(16'h0001, 16'h8000, '1);
      // symbol ahead of any begin runs from the empty subset
      offer_item(CMD_SYMBOL, '0, '0, '0, 8'h41);
      offer_item(CMD_BEGIN, '0, '0, '0, 8'h00);
      offer_item(CMD_SYMBOL, '0, '0, '0, 8'h00);
      offer_item(CMD_SYMBOL, '0, '0, '0, 8'h41);
      offer_item(CMD_SYMBOL, '0, '0, '0, 8'h55);
      // unknown byte kills the word; later symbols leave it dead
      offer_item(CMD_SYMBOL, '0, '0, '0, 8'h13);
      offer_item(CMD_SYMBOL, '1, '1, '1, 8'h00);
      offer_item(CMD_BEGIN, '1, '1, '1, 8'hFF);

      // Random phases, each under its own register setting
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         case (p)
            0: write_regs('1, '0, COUNT_W'(NUM_SYMBOLS));
            1: write_regs('0, '1, '0);
            2: write_regs(16'h0001, 16'h8000, '1);
            default: begin
               count_pick = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom)
                                                         : COUNT_W'($urandom_range(3, 8));
               write_regs(pick_mask(), pick_mask(), count_pick);
            end
         endcase
         if (p == 3 || p == 6) hold_offs_asked++;
         phase_end = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
         while (items_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               sym = BYTE_W'($urandom);
               if ($urandom_range(0, 3) == 0) begin
                  sym = loaded_bytes[$urandom_range(0, NUM_SYMBOLS - 1)];
               end
               offer_item(CMD_LOAD_ALPHA, STATE_W'($urandom), SLOT_W'($urandom),
                          MASK_W'($urandom), sym);
            end else if (pick < 25) begin
               offer_item(CMD_LOAD_ROW, STATE_W'($urandom), SLOT_W'($urandom), pick_mask(),
                          BYTE_W'($urandom));
            end else if (pick < 30) begin
               // noise: any command, any content
               offer_item(CMD_W'($urandom), STATE_W'($urandom), SLOT_W'($urandom),
                          MASK_W'($urandom), BYTE_W'($urandom));
            end else begin
               run_word();
            end
         end
      end

      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/nca_pkg.sv
hdl/nca_ram.sv
hdl/nfa_complement_acceptor.sv
tb/complement_run_checker.sv
tb/tb_top.sv
